FILE: src/qrfm_pkg.sv
// ============================================================================
// qrfm_pkg
// Shared types and constants for the replica-layer QUBO Metropolis flip block.
// ============================================================================
`default_nettype none

package qrfm_pkg;

   localparam int NUM_SPINS_DEF  = 64;
   localparam int NUM_LAYERS_DEF = 4;

   localparam int OP_W        = 2;
   localparam int LAYER_W     = 2;
   localparam int INDEX_W     = 6;
   localparam int LOAD_W      = 16;
   localparam int THRESHOLD_W = 24;
   localparam int ENERGY_W    = 40;
   localparam int GAIN_W      = 32;
   localparam int CLAMP_W     = 39;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 39;

   localparam logic [GAIN_W-1:0]  COUPLING_GAIN_RST   = 32'd65536;
   localparam logic [GAIN_W-1:0]  REPLICA_GAIN_RST    = 32'd0;
   localparam logic [GAIN_W-1:0]  INV_TEMPERATURE_RST = 32'd65536;
   localparam logic [CLAMP_W-1:0] CLAMP_LIMIT_RST     = 39'd65536000000;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_CPL  = 2'd0,
      OP_LOAD_SPIN = 2'd1,
      OP_FLIP      = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUPLING_GAIN   = 2'd0,
      CSR_REPLICA_GAIN    = 2'd1,
      CSR_INV_TEMPERATURE = 2'd2,
      CSR_CLAMP_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_NEXT,
      ST_RD_PREV,
      ST_SWEEP,
      ST_DRAIN,
      ST_MUL_CG,
      ST_ADD,
      ST_CLAMP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  coupling_gain;
      logic [GAIN_W-1:0]  replica_gain;
      logic [GAIN_W-1:0]  inv_temperature;
      logic [CLAMP_W-1:0] clamp_limit;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic rd_next;
      logic rd_prev;
      logic sweep;
      logic mul_cg;
      logic add;
      logic clamp;
      logic mul_lo;
      logic mul_hi;
      logic decide;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   spin_ok;
      logic   sweep_last;
      logic   rsp_free;
   } status_type;

endpackage

`default_nettype wire

FILE: src/qrfm_csr.sv
// ============================================================================
// qrfm_csr
// Configuration registers: gains, inverse temperature and energy clamp.
// ============================================================================
`default_nettype none

module qrfm_csr import qrfm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coupling_gain   <= COUPLING_GAIN_RST;
         cfg_ff.replica_gain    <= REPLICA_GAIN_RST;
         cfg_ff.inv_temperature <= INV_TEMPERATURE_RST;
         cfg_ff.clamp_limit     <= CLAMP_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COUPLING_GAIN:   cfg_ff.coupling_gain   <= csr_wr_data[GAIN_W-1:0];
            CSR_REPLICA_GAIN:    cfg_ff.replica_gain    <= csr_wr_data[GAIN_W-1:0];
            CSR_INV_TEMPERATURE: cfg_ff.inv_temperature <= csr_wr_data[GAIN_W-1:0];
            CSR_CLAMP_LIMIT:     cfg_ff.clamp_limit     <= csr_wr_data[CLAMP_W-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/qrfm_ctrl.sv
// ============================================================================
// qrfm_ctrl
// Sequencer that steps one transaction at a time through the datapath.
// ============================================================================
`default_nettype none

module qrfm_ctrl import qrfm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op == OP_FLIP && status.spin_ok) begin
               state_in = ST_RD_NEXT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_NEXT: state_in = ST_RD_PREV;
         ST_RD_PREV: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_MUL_CG;
         ST_MUL_CG: state_in = ST_ADD;
         ST_ADD:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_RD_NEXT: cmd.rd_next = 1'b1;
         ST_RD_PREV: cmd.rd_prev = 1'b1;
         ST_SWEEP:   cmd.sweep   = 1'b1;
         ST_MUL_CG:  cmd.mul_cg  = 1'b1;
         ST_ADD:     cmd.add     = 1'b1;
         ST_CLAMP:   cmd.clamp   = 1'b1;
         ST_MUL_LO:  cmd.mul_lo  = 1'b1;
         ST_MUL_HI:  cmd.mul_hi  = 1'b1;
         ST_DECIDE:  cmd.decide  = 1'b1;
         ST_DONE:    cmd.finish  = status.rsp_free;
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/qrfm_dp.sv
// ============================================================================
// qrfm_dp
// Datapath: spin and coupling memories, row accumulator, energy arithmetic,
// acceptance test and the result register.
// ============================================================================
`default_nettype none

module qrfm_dp import qrfm_pkg::*; #(
   parameter int NUM_SPINS  = NUM_SPINS_DEF,
   parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cmd_type                            cmd,
   input  cfg_type                            cfg,
   output status_type                         status,
   input  wire logic [OP_W-1:0]               req_op,
   input  wire logic [LAYER_W-1:0]            req_layer,
   input  wire logic [INDEX_W-1:0]            req_row_index,
   input  wire logic [INDEX_W-1:0]            req_col_index,
   input  wire logic signed [LOAD_W-1:0]      req_load_value,
   input  wire logic [THRESHOLD_W-1:0]        req_threshold,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_accepted,
   output logic                               rsp_spin_value,
   output logic signed [ENERGY_W-1:0]         rsp_energy_change
);

   localparam int IDX_W      = $clog2(NUM_SPINS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SPIN_DEPTH = NUM_LAYERS * NUM_SPINS;
   localparam int SPIN_AW    = $clog2(SPIN_DEPTH);
   localparam int CPL_DEPTH  = NUM_SPINS * NUM_SPINS;
   localparam int CPL_AW     = $clog2(CPL_DEPTH);
   localparam int SUM_W      = LOAD_W + IDX_W;
   localparam int DS_W       = SUM_W + 1;
   localparam int PROD_W     = DS_W + GAIN_W + 1;
   localparam int DE_W       = PROD_W - 7;
   localparam int REP_W      = GAIN_W + 3;
   localparam int HALF_W     = 20;
   localparam int MUL_W      = HALF_W + GAIN_W;
   localparam int TOT_W      = MUL_W + HALF_W;
   localparam int X_W        = THRESHOLD_W + 16;

   // Item fields held for the duration of the transaction.
   op_type                     op_ff;
   logic [LAYER_W-1:0]         layer_ff;
   logic [INDEX_W-1:0]         row_ff;
   logic [INDEX_W-1:0]         col_ff;
   logic [LOAD_W-1:0]          load_ff;
   logic [THRESHOLD_W-1:0]     thr_ff;
   logic                       cpl_ok_ff;
   logic                       spin_ok_ff;

   logic                       spin_mem_ff [SPIN_DEPTH];
   logic [LOAD_W-1:0]          cpl_mem_ff [CPL_DEPTH];
   logic                       spin_rd_ff;
   logic [LOAD_W-1:0]          cpl_rd_ff;

   logic [CNT_W-1:0]           cnt_ff;
   logic                       acc_vld_ff;
   logic [IDX_W-1:0]           acc_j_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic                       before_ff;
   logic                       nxt_ff;
   logic                       prv_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [DE_W-1:0]     raw_ff;
   logic signed [ENERGY_W-1:0] de_ff;
   logic [MUL_W-1:0]           pl_ff;
   logic [MUL_W-1:0]           ph_ff;
   logic                       keep_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_accepted_ff;
   logic                       rsp_spin_ff;
   logic signed [ENERGY_W-1:0] rsp_energy_ff;

   logic                       now;
   logic                       nb;
   logic                       pb;
   logic                       bit_j;
   logic [SPIN_AW-1:0]         self_addr;
   logic [SPIN_AW-1:0]         next_addr;
   logic [SPIN_AW-1:0]         prev_addr;
   logic [SPIN_AW-1:0]         spin_raddr;
   logic                       spin_we;
   logic                       spin_wdata;
   logic [CPL_AW-1:0]          cpl_addr;
   logic                       cpl_we;
   logic signed [DS_W-1:0]     ds;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [REP_W-1:0]    rep;
   logic signed [DE_W-1:0]     raw_in;
   logic signed [DE_W-1:0]     cl_pos;
   logic signed [DE_W-1:0]     cl_neg;
   logic signed [DE_W-1:0]     de_in;
   logic [HALF_W-1:0]          mul_a;
   logic [MUL_W-1:0]           mul_p;
   logic [TOT_W-1:0]           total;
   logic [X_W-1:0]             x_thr;
   logic                       keep_in;
   logic                       rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_op);
         layer_ff   <= req_layer;
         row_ff     <= req_row_index;
         col_ff     <= req_col_index;
         load_ff    <= req_load_value;
         thr_ff     <= req_threshold;
         cpl_ok_ff  <= (32'(req_row_index) < NUM_SPINS) && (32'(req_col_index) < NUM_SPINS);
         spin_ok_ff <= (32'(req_layer) < NUM_LAYERS) && (32'(req_row_index) < NUM_SPINS);
      end
   end

   always_comb begin
      self_addr = SPIN_AW'(int'(layer_ff) * NUM_SPINS + int'(row_ff));
      if (int'(layer_ff) == NUM_LAYERS - 1) begin
         next_addr = SPIN_AW'(int'(row_ff));
      end else begin
         next_addr = SPIN_AW'((int'(layer_ff) + 1) * NUM_SPINS + int'(row_ff));
      end
      if (layer_ff == '0) begin
         prev_addr = SPIN_AW'((NUM_LAYERS - 1) * NUM_SPINS + int'(row_ff));
      end else begin
         prev_addr = SPIN_AW'((int'(layer_ff) - 1) * NUM_SPINS + int'(row_ff));
      end
      priority if (cmd.rd_next) begin
         spin_raddr = next_addr;
      end else if (cmd.rd_prev) begin
         spin_raddr = prev_addr;
      end else if (cmd.sweep) begin
         spin_raddr = SPIN_AW'(int'(layer_ff) * NUM_SPINS + int'(cnt_ff[IDX_W-1:0]));
      end else begin
         spin_raddr = self_addr;
      end
      if (cmd.sweep) begin
         cpl_addr = CPL_AW'(int'(row_ff) * NUM_SPINS + int'(cnt_ff[IDX_W-1:0]));
      end else begin
         cpl_addr = CPL_AW'(int'(row_ff) * NUM_SPINS + int'(col_ff));
      end
   end

   assign now        = ~before_ff;
   assign spin_we    = cmd.finish && spin_ok_ff
                       && (op_ff == OP_LOAD_SPIN || (op_ff == OP_FLIP && keep_ff));
   assign spin_wdata = (op_ff == OP_LOAD_SPIN) ? load_ff[0] : now;
   assign cpl_we     = cmd.finish && cpl_ok_ff && op_ff == OP_LOAD_CPL;

   always_ff @(posedge clock) begin
      if (spin_we) begin
         spin_mem_ff[self_addr] <= spin_wdata;
      end
      spin_rd_ff <= spin_mem_ff[spin_raddr];
   end

   always_ff @(posedge clock) begin
      if (cpl_we) begin
         cpl_mem_ff[cpl_addr] <= load_ff;
      end
      cpl_rd_ff <= cpl_mem_ff[cpl_addr];
   end

   // The flipped bit itself is taken as its new value during the row sweep.
   assign bit_j = (acc_j_ff == IDX_W'(row_ff)) ? now : spin_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         acc_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cmd.sweep ? cnt_ff + 1'b1 : '0;
         acc_vld_ff <= cmd.sweep;
      end
   end

   always_ff @(posedge clock) begin
      acc_j_ff <= cnt_ff[IDX_W-1:0];
      if (cmd.rd_next) begin
         before_ff <= spin_rd_ff;
      end
      if (cmd.rd_prev) begin
         nxt_ff <= spin_rd_ff;
      end
      if (cmd.sweep && cnt_ff == '0) begin
         prv_ff <= spin_rd_ff;
      end
      priority if (acc_vld_ff) begin
         if (bit_j) begin
            sum_ff <= sum_ff + SUM_W'($signed(cpl_rd_ff));
         end
      end else if (cmd.sweep && cnt_ff == '0) begin
         sum_ff <= '0;
      end
   end

   assign ds      = now ? DS_W'(sum_ff) : -DS_W'(sum_ff);
   assign prod_in = ds * $signed({1'b0, cfg.coupling_gain});
   assign nb      = (NUM_LAYERS == 1) ? now : nxt_ff;
   assign pb      = (NUM_LAYERS == 1) ? now : prv_ff;

   always_comb begin
      if (nb != pb) begin
         rep = '0;
      end else if (nb == now) begin
         rep = $signed({2'b00, cfg.replica_gain, 1'b0});
      end else begin
         rep = -$signed({2'b00, cfg.replica_gain, 1'b0});
      end
   end

   assign raw_in = DE_W'($signed(prod_ff[PROD_W-1:8])) + DE_W'(rep);
   assign cl_pos = $signed(DE_W'(cfg.clamp_limit));
   assign cl_neg = -cl_pos;

   always_comb begin
      priority if (raw_ff > cl_pos) begin
         de_in = cl_pos;
      end else if (raw_ff < cl_neg) begin
         de_in = cl_neg;
      end else begin
         de_in = raw_ff;
      end
   end

   assign mul_a = cmd.mul_lo ? de_ff[HALF_W-1:0] : {1'b0, de_ff[CLAMP_W-1:HALF_W]};
   assign mul_p = mul_a * cfg.inv_temperature;
   assign total = {ph_ff, {HALF_W{1'b0}}} + TOT_W'(pl_ff);
   assign x_thr = {thr_ff, 16'h0000};

   always_comb begin
      priority if (cfg.inv_temperature == '0 || de_ff == '0) begin
         keep_in = thr_ff != '0;
      end else if (de_ff < 0) begin
         keep_in = 1'b1;
      end else begin
         keep_in = total < TOT_W'(x_thr);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_cg) begin
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         raw_ff <= raw_in;
      end
      if (cmd.clamp) begin
         de_ff <= de_in[ENERGY_W-1:0];
      end
      if (cmd.mul_lo) begin
         pl_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         ph_ff <= mul_p;
      end
      if (cmd.decide) begin
         keep_ff <= keep_in;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (spin_ok_ff && op_ff == OP_FLIP) begin
            rsp_accepted_ff <= keep_ff;
            rsp_spin_ff     <= before_ff ^ keep_ff;
            rsp_energy_ff   <= de_ff;
         end else if (spin_ok_ff && op_ff == OP_READ) begin
            rsp_accepted_ff <= 1'b0;
            rsp_spin_ff     <= spin_rd_ff;
            rsp_energy_ff   <= '0;
         end else begin
            rsp_accepted_ff <= 1'b0;
            rsp_spin_ff     <= 1'b0;
            rsp_energy_ff   <= '0;
         end
      end
   end

   assign status.op         = op_ff;
   assign status.spin_ok    = spin_ok_ff;
   assign status.sweep_last = cnt_ff == CNT_W'(NUM_SPINS - 1);
   assign status.rsp_free   = rsp_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_spin_value    = rsp_spin_ff;
   assign rsp_energy_change = rsp_energy_ff;

endmodule

`default_nettype wire

FILE: src/qubo_replica_flip_metropolis.sv
// ============================================================================
// qubo_replica_flip_metropolis
// Single-flip Metropolis step over replicated QUBO spin layers.
// ============================================================================
// The block handles one transaction at a time. Coupling loads, spin loads,
// spin reads and out-of-range requests pass through the decode and done
// states before the next request can be taken. In a flip attempt the
// coupling row is swept one entry per cycle through the single read port
// of the coupling memory, followed by the gain multiply, the clamp, a
// two-pass multiply by the inverse temperature and the accept decision. The
// spin and coupling memories come out of reset with undefined contents and
// must be loaded before they are read; there is no clearing pass. A new
// request is taken while a previous result still waits on the output.
// ============================================================================
`default_nettype none

module qubo_replica_flip_metropolis import qrfm_pkg::*; #(
   parameter int NUM_SPINS  = NUM_SPINS_DEF,
   parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic [LAYER_W-1:0]       req_layer,
   input  wire logic [INDEX_W-1:0]       req_row_index,
   input  wire logic [INDEX_W-1:0]       req_col_index,
   input  wire logic signed [LOAD_W-1:0] req_load_value,
   input  wire logic [THRESHOLD_W-1:0]   req_threshold,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_spin_value,
   output logic signed [ENERGY_W-1:0]    rsp_energy_change,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   qrfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   qrfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   qrfm_dp #(
      .NUM_SPINS  (NUM_SPINS),
      .NUM_LAYERS (NUM_LAYERS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .status            (status),
      .req_op            (req_op),
      .req_layer         (req_layer),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_load_value    (req_load_value),
      .req_threshold     (req_threshold),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_spin_value    (rsp_spin_value),
      .rsp_energy_change (rsp_energy_change)
   );

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("Block took a transaction without becoming busy.");

   a_result_from_work: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("Result appeared without a transaction in progress.");

   a_energy_clamped: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_energy_change <= $signed({1'b0, cfg.clamp_limit}))
                 && (rsp_energy_change >= -$signed({1'b0, cfg.clamp_limit}))
   ) else $error("Reported energy change exceeds the clamp limit.");

endmodule

`default_nettype wire
